@@ design/mplf_pkg.sv @@
// ----------------------------------------------------------------------------
// mplf_pkg
// Shared types and constants of the multi-pattern line filter.
// ----------------------------------------------------------------------------
`default_nettype none
package mplf_pkg;

   localparam int MAX_PATTERNS    = 8;
   localparam int MAX_PATTERN_LEN = 32;
   localparam int COUNT_WIDTH     = 32;
   localparam int IDX_W           = $clog2(MAX_PATTERNS);
   localparam int POS_W           = $clog2(MAX_PATTERN_LEN);
   localparam int LEN_W           = $clog2(MAX_PATTERN_LEN + 1);
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

   // input item kinds
   localparam logic [2:0] KIND_TEXT    = 3'd0;
   localparam logic [2:0] KIND_EOL     = 3'd1;
   localparam logic [2:0] KIND_EOI     = 3'd2;
   localparam logic [2:0] KIND_PAT_BYTE = 3'd3;
   localparam logic [2:0] KIND_PAT_LEN = 3'd4;

   // register indexes
   localparam logic [0:0] CSR_MATCH_MODE    = 1'd0;
   localparam logic [0:0] CSR_PATTERN_COUNT = 1'd1;

   localparam logic RES_LINE  = 1'b0;
   localparam logic RES_TOTAL = 1'b1;

   // classified line event passed from front to back
   typedef struct packed {
      logic                    is_eoi;   // end of input (else end of line)
      logic                    was_open; // line had text bytes
      logic [MAX_PATTERNS-1:0] found;    // found or empty per pattern
   } event_type;

   // one result record
   typedef struct packed {
      logic        result_kind;
      logic [31:0] line_number;
      logic [31:0] matching_total;
      logic        last;
   } result_type;

endpackage
`default_nettype wire

@@ design/mplf_front.sv @@
// ----------------------------------------------------------------------------
// mplf_front
// Pattern store and sliding window; compares every pattern against the window
// each text byte and hands line-close events to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module mplf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire logic [2:0]          item_kind,
   input  wire logic [7:0]          item_byte,
   input  wire logic [2:0]          item_index,
   input  wire logic [4:0]          item_position,
   input  wire logic [5:0]          item_length,
   output mplf_pkg::event_type      evt,
   output logic                     evt_valid
);
   localparam int N = mplf_pkg::MAX_PATTERNS;
   localparam int L = mplf_pkg::MAX_PATTERN_LEN;

   logic [7:0] pat_ff [N][L];
   logic [mplf_pkg::LEN_W-1:0] len_ff [N];
   logic [7:0] win_ff [L];
   logic [mplf_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic [N-1:0] flags_ff, flags_in;
   logic open_ff, open_in;
   logic [N-1:0] hit;
   logic [mplf_pkg::LEN_W-1:0] fill_next;
   logic idx_ok, pos_ok;

   assign idx_ok = 32'(item_index) < N;
   assign pos_ok = 32'(item_position) < L;
   assign fill_next = (32'(fill_ff) < L) ? fill_ff + 1'b1 : fill_ff;

   // parallel window compare: new byte counts as the newest window entry
   always_comb begin
      for (int p = 0; p < N; p++) begin
         hit[p] = (len_ff[p] != '0) && (len_ff[p] <= fill_next);
         for (int k = 0; k < L; k++) begin
            if (k < 32'(len_ff[p])) begin
               if (((k == 32'(len_ff[p]) - 1) ? item_byte
                    : win_ff[L - 32'(len_ff[p]) + k + 1]) != pat_ff[p][k])
                  hit[p] = 1'b0;
            end
         end
      end
   end

   // line state
   always_comb begin
      fill_in  = fill_ff;
      flags_in = flags_ff;
      open_in  = open_ff;
      evt_valid = 1'b0;
      for (int p = 0; p < N; p++) evt.found[p] = flags_ff[p] || (len_ff[p] == '0);
      evt.is_eoi   = (item_kind == mplf_pkg::KIND_EOI);
      evt.was_open = open_ff;
      if (item_valid) begin
         case (item_kind)
            mplf_pkg::KIND_TEXT: begin
               fill_in  = fill_next;
               flags_in = flags_ff | hit;
               open_in  = 1'b1;
            end
            mplf_pkg::KIND_EOL, mplf_pkg::KIND_EOI: begin
               evt_valid = 1'b1;
               fill_in   = '0;
               flags_in  = '0;
               open_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         flags_ff <= '0;
         open_ff  <= 1'b0;
         for (int p = 0; p < N; p++) len_ff[p] <= '0;
      end else begin
         fill_ff  <= fill_in;
         flags_ff <= flags_in;
         open_ff  <= open_in;
         if (item_valid && item_kind == mplf_pkg::KIND_PAT_LEN && idx_ok)
            len_ff[item_index[mplf_pkg::IDX_W-1:0]] <= (32'(item_length) > L)
               ? mplf_pkg::LEN_W'(L) : item_length[mplf_pkg::LEN_W-1:0];
      end
   end

   // payload storage: window shift and pattern bytes
   always_ff @(posedge clock) begin
      if (item_valid && item_kind == mplf_pkg::KIND_TEXT) begin
         for (int k = 0; k < L - 1; k++) win_ff[k] <= win_ff[k+1];
         win_ff[L-1] <= item_byte;
      end
      if (item_valid && item_kind == mplf_pkg::KIND_PAT_BYTE && idx_ok && pos_ok)
         pat_ff[item_index[mplf_pkg::IDX_W-1:0]][item_position[mplf_pkg::POS_W-1:0]]
            <= item_byte;
   end
endmodule
`default_nettype wire

@@ design/mplf_back.sv @@
// ----------------------------------------------------------------------------
// mplf_back
// Takes line events from a short queue, applies mode and count, keeps line and
// match counters, emits results (two if end of input closes a matching line).
// ----------------------------------------------------------------------------
`default_nettype none
module mplf_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                match_mode,
   input  wire logic [3:0]          pattern_count,
   input  wire logic                evt_push,
   input  wire mplf_pkg::event_type evt,
   output logic                     evt_full,
   output mplf_pkg::result_type     rsp,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop
);
   localparam int N  = mplf_pkg::MAX_PATTERNS;
   localparam int CW = mplf_pkg::COUNT_WIDTH;
   localparam int AW = mplf_pkg::FIFO_AW;

   // event queue
   mplf_pkg::event_type q_ff [mplf_pkg::FIFO_DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          q_pop;
   mplf_pkg::event_type head;

   // counters and output stage (two slots: line report then total)
   logic [CW-1:0] lines_ff, lines_in, match_ff, match_in;
   logic [1:0]    ov_ff, ov_in;          // ov[0] head slot, ov[1] second slot
   mplf_pkg::result_type o0_ff, o0_in, o1_ff, o1_in;
   logic hit, any_f, all_f, closing;
   logic [CW-1:0] lines_inc, match_inc;
   mplf_pkg::result_type rline, rtot;

   assign evt_full = (cnt_ff == (AW+1)'(mplf_pkg::FIFO_DEPTH));
   assign head     = q_ff[rp_ff];

   // match decision over the used patterns
   always_comb begin
      any_f = 1'b0;
      all_f = 1'b1;
      for (int p = 0; p < N; p++) begin
         if (p < ((32'(pattern_count) > N) ? N : 32'(pattern_count))) begin
            any_f = any_f | head.found[p];
            all_f = all_f & head.found[p];
         end
      end
      hit = match_mode ? all_f : any_f;
   end

   always_comb begin
      lines_inc = (lines_ff == '1) ? lines_ff : lines_ff + 1'b1;
      closing   = !head.is_eoi || head.was_open;
      match_inc = (closing && hit && match_ff != '1) ? match_ff + 1'b1 : match_ff;
      rline.result_kind    = mplf_pkg::RES_LINE;
      rline.line_number    = 32'(lines_inc);
      rline.matching_total = 32'(match_inc);
      rline.last           = !head.is_eoi;
      rtot.result_kind     = mplf_pkg::RES_TOTAL;
      rtot.line_number     = '0;
      rtot.matching_total  = 32'(match_inc);
      rtot.last            = 1'b1;
   end

   // output slots shift on pop; a new event loads only when both are free
   always_comb begin
      ov_in = ov_ff;
      o0_in = o0_ff;
      o1_in = o1_ff;
      lines_in = lines_ff;
      match_in = match_ff;
      if (rsp_pop && ov_ff[0]) begin
         ov_in = {1'b0, ov_ff[1]};
         o0_in = o1_ff;
      end
      q_pop = (cnt_ff != '0) && (ov_in == 2'b00);
      if (q_pop) begin
         if (head.is_eoi) begin
            lines_in = '0;
            match_in = '0;
            if (closing && hit) begin
               o0_in = rline; o1_in = rtot; ov_in = 2'b11;
            end else begin
               o0_in = rtot; ov_in = 2'b01;
            end
         end else begin
            lines_in = lines_inc;
            match_in = match_inc;
            if (hit) begin
               o0_in = rline; ov_in = 2'b01;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
         ov_ff <= '0; lines_ff <= '0; match_ff <= '0;
      end else begin
         if (evt_push && !evt_full) wp_ff <= wp_ff + 1'b1;
         if (q_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff   <= cnt_ff + (AW+1)'(evt_push && !evt_full) - (AW+1)'(q_pop);
         ov_ff    <= ov_in;
         lines_ff <= lines_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_push && !evt_full) q_ff[wp_ff] <= evt;
      o0_ff <= o0_in;
      o1_ff <= o1_in;
   end

   assign rsp       = o0_ff;
   assign rsp_empty = !ov_ff[0];
endmodule
`default_nettype wire

@@ design/multi_pattern_line_filter_unit.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_line_filter_unit
// Line filter that reports lines holding any or all of up to eight patterns.
// ----------------------------------------------------------------------------
// Takes one request per cycle while full is low: text bytes are compared
// against every loaded pattern in parallel in the front end the cycle they
// arrive. Line ends go through a four-entry event queue to the back end,
// which takes the next event only once both result slots are free; an end
// of input that also closes a matching line fills both (two results). full
// rises when the event queue fills: when results are not being popped, or
// when such two-result ends of input arrive faster than they are drained.
`default_nettype none
module multi_pattern_line_filter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [2:0]  req_kind,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic [2:0]  req_pattern_index,
   input  wire logic [4:0]  req_pattern_position,
   input  wire logic [5:0]  req_pattern_length,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic             rsp_result_kind,
   output logic [31:0]      rsp_line_number,
   output logic [31:0]      rsp_matching_total,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [3:0]  csr_data
);
   logic mode_ff;
   logic [3:0] count_ff;
   logic accept, evt_valid, evt_full;
   mplf_pkg::event_type evt;
   mplf_pkg::result_type rsp;

   assign csr_ready = 1'b1;
   assign req_full  = evt_full;
   assign accept    = req_push && !evt_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            mplf_pkg::CSR_MATCH_MODE:    mode_ff  <= csr_data[0];
            mplf_pkg::CSR_PATTERN_COUNT: count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mplf_front u_front (
      .clock, .reset,
      .item_valid(accept), .item_kind(req_kind), .item_byte(req_byte_value),
      .item_index(req_pattern_index), .item_position(req_pattern_position),
      .item_length(req_pattern_length), .evt, .evt_valid
   );

   mplf_back u_back (
      .clock, .reset, .match_mode(mode_ff), .pattern_count(count_ff),
      .evt_push(evt_valid), .evt, .evt_full, .rsp, .rsp_empty, .rsp_pop
   );

   assign rsp_result_kind    = rsp.result_kind;
   assign rsp_line_number    = rsp.line_number;
   assign rsp_matching_total = rsp.matching_total;
   assign rsp_last           = rsp.last;
endmodule
`default_nettype wire

@@ design/mplf_checker.sv @@
// ----------------------------------------------------------------------------
// mplf_checker
// Port-level checks of the line filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mplf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic        rsp_result_kind,
   input wire logic [31:0] rsp_line_number,
   input wire logic        rsp_last
);
   // a total never carries a line number and is always last
   a_total: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_result_kind |-> rsp_line_number == '0 && rsp_last)
      else $error("bad total record");
   // a line report is never shown with number zero
   a_line: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_result_kind |-> rsp_line_number != '0)
      else $error("zero line number");
   // a non-last line report is followed by its total
   a_pair: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && !rsp_last |=> !rsp_empty && rsp_result_kind)
      else $error("total missing after line report");
   // nothing visible right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result after reset");
endmodule

bind multi_pattern_line_filter_unit mplf_checker u_chk (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_result_kind,
   .rsp_line_number, .rsp_last
);
`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-pattern line filter unit.
// ----------------------------------------------------------------------------
// Loads patterns and streams text lines through the request queue port.
// A request-level predictor computes the expected line reports and totals,
// and the monitor compares every popped result against them. Phases run
// under several match mode and pattern count settings, including extremes.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int NP           = mplf_pkg::MAX_PATTERNS;
   localparam int PL           = mplf_pkg::MAX_PATTERN_LEN;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] byte_value;
      logic [2:0] pattern_index;
      logic [4:0] pattern_position;
      logic [5:0] pattern_length;
   } request_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_kind;
   logic [7:0]  req_byte_value;
   logic [2:0]  req_pattern_index;
   logic [4:0]  req_pattern_position;
   logic [5:0]  req_pattern_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_result_kind;
   logic [31:0] rsp_line_number;
   logic [31:0] rsp_matching_total;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [3:0]  csr_data;

   multi_pattern_line_filter_unit i_dut (.*);

   // request and result bookkeeping
   request_type pending_requests[$];
   mplf_pkg::result_type expected_results[$];
   logic        req_taken;
   logic        no_idle;
   int          error_count;
   int          cycle_count;

   // predictor state
   logic [7:0]  pat_bytes[NP][PL];
   logic [5:0]  pat_len[NP];
   logic [7:0]  window[PL];
   int          line_bytes;
   logic [7:0]  found;
   logic        line_open;
   logic [31:0] line_count;
   logic [31:0] match_count;
   logic        mode_all;
   logic [3:0]  used_count;

   // generator view of loaded patterns
   logic [7:0]  gen_bytes[NP][PL];
   logic [31:0] gen_written[NP];
   int          gen_len[NP];

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   // close the line in the predictor, return line match
   function automatic logic close_line();
      int  used;
      logic any_hit, all_hit, hit, f;
      used    = (used_count > NP) ? NP : used_count;
      any_hit = 1'b0;
      all_hit = 1'b1;
      for (int p = 0; p < used; p++) begin
         f       = (pat_len[p] == 0) || found[p];
         any_hit = any_hit | f;
         all_hit = all_hit & f;
      end
      hit        = mode_all ? all_hit : any_hit;
      line_count = sat_inc(line_count);
      if (hit) match_count = sat_inc(match_count);
      found      = '0;
      line_bytes = 0;
      line_open  = 1'b0;
      return hit;
   endfunction

   // advance the predictor by one accepted request
   task automatic predict_request(request_type r);
      logic eq;
      int   len;
      case (r.kind)
         mplf_pkg::KIND_TEXT: begin
            for (int k = 0; k < PL - 1; k++) window[k] = window[k+1];
            window[PL-1] = r.byte_value;
            if (line_bytes < PL) line_bytes++;
            line_open = 1'b1;
            for (int p = 0; p < NP; p++) begin
               len = pat_len[p];
               if (len != 0 && len <= line_bytes) begin
                  eq = 1'b1;
                  for (int k = 0; k < len; k++)
                     if (window[PL-len+k] != pat_bytes[p][k]) eq = 1'b0;
                  if (eq) found[p] = 1'b1;
               end
            end
         end
         mplf_pkg::KIND_EOL: begin
            if (close_line())
               expected_results.push_back('{mplf_pkg::RES_LINE, line_count,
                                            match_count, 1'b1});
         end
         mplf_pkg::KIND_EOI: begin
            if (line_open && close_line())
               expected_results.push_back('{mplf_pkg::RES_LINE, line_count,
                                            match_count, 1'b0});
            expected_results.push_back('{mplf_pkg::RES_TOTAL, 32'd0, match_count, 1'b1});
            line_count  = '0;
            match_count = '0;
            found       = '0;
            line_bytes  = 0;
            line_open   = 1'b0;
         end
         mplf_pkg::KIND_PAT_BYTE:
            pat_bytes[r.pattern_index][r.pattern_position] = r.byte_value;
         mplf_pkg::KIND_PAT_LEN:
            pat_len[r.pattern_index] = (r.pattern_length > PL) ?
                                       6'(PL) : r.pattern_length;
         default: ;
      endcase
   endtask

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
         req_push <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   (no_idle || $urandom_range(99) >= 8)) begin
         request_type r;
         r = pending_requests.pop_front();
         req_push             <= 1'b1;
         req_kind             <= r.kind;
         req_byte_value       <= r.byte_value;
         req_pattern_index    <= r.pattern_index;
         req_pattern_position <= r.pattern_position;
         req_pattern_length   <= r.pattern_length;
      end else begin
         req_push <= 1'b0;
      end
   end

   // result pop pacing
   always @(negedge clock)
      rsp_pop <= !reset && (no_idle || $urandom_range(99) >= 8);

   // accept requests, check results
   always @(posedge clock) begin
      req_taken <= 1'b0;
      if (!reset) begin
         if (req_push && !req_full) begin
            req_taken <= 1'b1;
            predict_request({req_kind, req_byte_value, req_pattern_index,
                             req_pattern_position, req_pattern_length});
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result kind=%0d line=%0d total=%0d",
                      rsp_result_kind, rsp_line_number, rsp_matching_total);
               error_count++;
            end else begin
               mplf_pkg::result_type e;
               e = expected_results.pop_front();
               if (rsp_result_kind !== e.result_kind) begin
                  $error("result_kind expected %0d got %0d", e.result_kind, rsp_result_kind);
                  error_count++;
               end
               if (rsp_line_number !== e.line_number) begin
                  $error("line_number expected %0d got %0d", e.line_number, rsp_line_number);
                  error_count++;
               end
               if (rsp_matching_total !== e.matching_total) begin
                  $error("matching_total expected %0d got %0d",
                         e.matching_total, rsp_matching_total);
                  error_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last expected %0d got %0d", e.last, rsp_last);
                  error_count++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_pattern_line_filter_unit test failed");
         $finish;
      end
   end

   task automatic add_request(logic [2:0] kind, logic [7:0] b = 8'd0,
                              logic [2:0] idx = 3'd0, logic [4:0] pos = 5'd0,
                              logic [5:0] len = 6'd0);
      pending_requests.push_back({kind, b, idx, pos, len});
   endtask

   // write pattern bytes as needed, then set its length
   task automatic load_pattern(int idx, int len, bit fresh);
      int eff;
      logic [7:0] b;
      eff = (len > PL) ? PL : len;
      for (int k = 0; k < eff; k++) begin
         if (fresh || !gen_written[idx][k]) begin
            b = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100));
            gen_bytes[idx][k]   = b;
            gen_written[idx][k] = 1'b1;
            add_request(mplf_pkg::KIND_PAT_BYTE, b, 3'(idx), 5'(k));
         end
      end
      gen_len[idx] = eff;
      add_request(mplf_pkg::KIND_PAT_LEN, 8'($urandom), 3'(idx), 5'($urandom), 6'(len));
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return 0;
      if (r < 80) return $urandom_range(1, 4);
      if (r < 94) return $urandom_range(5, 32);
      return $urandom_range(33, 63);
   endfunction

   // one text line with embedded pattern copies, ended by line or input end
   task automatic add_line();
      int pieces, p;
      pieces = $urandom_range(0, 10);
      for (int i = 0; i < pieces; i++) begin
         if ($urandom_range(99) < 35) begin
            p = $urandom_range(NP - 1);
            for (int k = 0; k < gen_len[p]; k++)
               add_request(mplf_pkg::KIND_TEXT, gen_bytes[p][k]);
         end else if ($urandom_range(99) < 10) begin
            add_request(mplf_pkg::KIND_TEXT, 8'($urandom));
         end else begin
            add_request(mplf_pkg::KIND_TEXT, 8'($urandom_range(97, 100)));
         end
         if ($urandom_range(99) < 3)
            load_pattern($urandom_range(NP - 1), pick_length(), 1'b1);
      end
      if ($urandom_range(99) < 8) add_request(mplf_pkg::KIND_EOI);
      else                        add_request(mplf_pkg::KIND_EOL);
      if ($urandom_range(99) < 2)
         add_request(3'($urandom_range(5, 7)), 8'($urandom), 3'($urandom),
                     5'($urandom), 6'($urandom));
   endtask

   task automatic csr_write(logic [0:0] idx, logic [3:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == mplf_pkg::CSR_MATCH_MODE) mode_all = value[0];
      else                                 used_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold the sender until everything sent has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_push || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // stimulus
   initial begin
      logic [3:0] modes[8];
      logic [3:0] counts[8];
      int phase_items;
      modes  = '{0, 1, 0, 1, 0, 1, 0, 1};
      counts = '{2, 0, 0, 8, 8, 15, 5, 3};
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      req_push  = 1'b0;
      req_kind = '0; req_byte_value = '0; req_pattern_index = '0;
      req_pattern_position = '0; req_pattern_length = '0;
      rsp_pop   = 1'b0;
      req_taken = 1'b0;
      no_idle   = 1'b0;
      error_count = 0;
      cycle_count = 0;
      mode_all = 1'b0; used_count = '0;
      line_bytes = 0; found = '0; line_open = 1'b0;
      line_count = '0; match_count = '0;
      for (int p = 0; p < NP; p++) begin
         pat_len[p] = '0; gen_len[p] = 0; gen_written[p] = '0;
      end
      @(negedge reset);

      // directed: short pattern, empty pattern, odd bytes, input end cases
      csr_write(mplf_pkg::CSR_MATCH_MODE, 4'd0);
      csr_write(mplf_pkg::CSR_PATTERN_COUNT, 4'd2);
      add_request(mplf_pkg::KIND_PAT_BYTE, "a", 3'd0, 5'd0);
      add_request(mplf_pkg::KIND_PAT_BYTE, "b", 3'd0, 5'd1);
      add_request(mplf_pkg::KIND_PAT_LEN, 8'd0, 3'd0, 5'd0, 6'd2);
      for (int p = 0; p < 8; p++) begin gen_bytes[0][p] = p[0] ? "b" : "a"; end
      gen_written[0] = 32'h3; gen_len[0] = 2;
      add_request(mplf_pkg::KIND_EOL);
      add_request(mplf_pkg::KIND_TEXT, "a"); add_request(mplf_pkg::KIND_TEXT, "b");
      add_request(mplf_pkg::KIND_EOL);
      add_request(mplf_pkg::KIND_TEXT, 8'h00); add_request(mplf_pkg::KIND_TEXT, 8'hFF);
      add_request(mplf_pkg::KIND_TEXT, 8'h0A); add_request(mplf_pkg::KIND_EOL);
      add_request(3'd7, 8'hFF, 3'd7, 5'd31, 6'd63);
      add_request(mplf_pkg::KIND_TEXT, "a"); add_request(mplf_pkg::KIND_TEXT, "b");
      add_request(mplf_pkg::KIND_EOI);
      add_request(mplf_pkg::KIND_EOI);
      add_request(mplf_pkg::KIND_PAT_LEN, 8'd0, 3'd1, 5'd0, 6'd0);
      add_request(mplf_pkg::KIND_TEXT, "c"); add_request(mplf_pkg::KIND_EOI);
      wait_idle();

      // pattern at its longest, via an oversized length
      load_pattern(7, 63, 1'b1);
      for (int k = 0; k < PL; k++) add_request(mplf_pkg::KIND_TEXT, gen_bytes[7][k]);
      add_request(mplf_pkg::KIND_EOL);
      for (int p = 1; p < NP - 1; p++) load_pattern(p, pick_length(), 1'b1);
      wait_idle();

      // random phases under a range of settings
      for (int ph = 0; ph < 10; ph++) begin
         no_idle = (ph == 3);
         if (ph < 8) begin
            csr_write(mplf_pkg::CSR_MATCH_MODE, modes[ph]);
            csr_write(mplf_pkg::CSR_PATTERN_COUNT, counts[ph]);
         end else begin
            csr_write(mplf_pkg::CSR_MATCH_MODE, 4'($urandom_range(1)));
            csr_write(mplf_pkg::CSR_PATTERN_COUNT, 4'($urandom_range(15)));
         end
         if ($urandom_range(1)) load_pattern($urandom_range(7), pick_length(), 1'b1);
         phase_items = pending_requests.size() + 200;
         while (pending_requests.size() < phase_items) add_line();
         add_request(mplf_pkg::KIND_EOI);
         wait_idle();
      end
      no_idle = 1'b0;

      if (error_count == 0 && expected_results.size() == 0)
         $display("multi_pattern_line_filter_unit test passed");
      else
         $display("multi_pattern_line_filter_unit test failed");
      $finish;
   end

endmodule
`default_nettype wire
